>>> rtl/rvs_pkg.sv
package rvs_pkg;

	localparam int DATA_WORDS_DEF = 4096;
	localparam int INSTR_WORDS_DEF = 2048;
	localparam int REG_COUNT = 32;

	localparam logic [31:0] START_PC_RESET = 32'h0000_1000;

	localparam logic [6:0] OP_LOAD = 7'h03;
	localparam logic [6:0] OP_STORE = 7'h23;
	localparam logic [6:0] OP_BRANCH = 7'h63;
	localparam logic [6:0] OP_REG = 7'h33;
	localparam logic [6:0] OP_IMM = 7'h13;

	localparam logic [2:0] F3_ADD = 3'd0;
	localparam logic [2:0] F3_SLT = 3'd2;
	localparam logic [2:0] F3_OR = 3'd6;
	localparam logic [2:0] F3_AND = 3'd7;
	localparam logic [6:0] F7_SUB = 7'h20;

	typedef enum logic [1:0] {
		CMD_LOAD_INSTR = 2'd0,
		CMD_LOAD_DATA = 2'd1,
		CMD_WRITE_REG = 2'd2,
		CMD_EXEC = 2'd3
	} cmd_t;

	typedef struct packed {
		cmd_t cmd;
		logic [11:0] mem_index;
		logic [4:0] reg_index;
		logic [31:0] load_value;
	} cmd_item_t;

	typedef struct packed {
		logic [31:0] pc;
		logic [31:0] instruction;
		logic signed [31:0] alu_value;
		logic reg_written;
		logic [4:0] dest_reg;
		logic [31:0] write_value;
		logic mem_written;
		logic [11:0] mem_word_address;
		logic [31:0] store_value;
		logic branch_taken;
		logic [31:0] next_pc;
	} res_item_t;

	typedef struct packed {
		logic [31:0] alu;
		logic [4:0] rd;
		logic reg_we;
		logic is_load;
		logic mem_we;
		logic [29:0] word_addr;
		logic [11:0] mem_addr;
		logic [31:0] store_value;
		logic taken;
		logic [31:0] next_pc;
	} ex_t;

	function automatic logic [31:0] imm_i(input logic [31:0] w);
		return {{20{w[31]}}, w[31:20]};
	endfunction

	function automatic logic [31:0] imm_s(input logic [31:0] w);
		return {{20{w[31]}}, w[31:25], w[11:7]};
	endfunction

	function automatic logic [31:0] imm_b(input logic [31:0] w);
		return {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
	endfunction

endpackage

>>> rtl/rvs_ram.sv
module rvs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = rvs_pkg::REG_COUNT
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic                                   re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> rtl/rvs_exec.sv
module rvs_exec #(
	parameter int DATA_WORDS = rvs_pkg::DATA_WORDS_DEF
) (
	input  logic [31:0]   instr,
	input  logic [31:0]   pc,
	input  logic [31:0]   rs1_val,
	input  logic [31:0]   rs2_val,
	output rvs_pkg::ex_t  ex
);

	logic [6:0] op;
	logic [2:0] f3;
	logic [6:0] f7;
	logic [4:0] rd;
	logic [31:0] src;
	logic [31:0] alu;
	logic is_load;
	logic is_store;
	logic alu_wr;
	logic taken;
	logic addr_ok;
	logic [31:0] pc_plus4;
	logic [31:0] pc_branch;

	assign op = instr[6:0];
	assign f3 = instr[14:12];
	assign f7 = instr[31:25];
	assign rd = instr[11:7];
	assign pc_plus4 = pc + 32'd4;
	assign pc_branch = pc + rvs_pkg::imm_b(instr);

	always_comb begin
		alu = rs1_val + rs2_val;
		src = rs2_val;
		is_load = 1'b0;
		is_store = 1'b0;
		alu_wr = 1'b0;
		taken = 1'b0;
		unique case (op)
			rvs_pkg::OP_LOAD: begin
				alu = rs1_val + rvs_pkg::imm_i(instr);
				is_load = 1'b1;
			end
			rvs_pkg::OP_STORE: begin
				alu = rs1_val + rvs_pkg::imm_s(instr);
				is_store = 1'b1;
			end
			rvs_pkg::OP_BRANCH: begin
				alu = rs1_val - rs2_val;
				taken = (alu == 32'd0);
			end
			rvs_pkg::OP_REG, rvs_pkg::OP_IMM: begin
				src = (op == rvs_pkg::OP_IMM) ? rvs_pkg::imm_i(instr) : rs2_val;
				alu_wr = 1'b1;
				unique case (f3)
					rvs_pkg::F3_ADD: begin
						alu = (op == rvs_pkg::OP_REG && f7 == rvs_pkg::F7_SUB) ?
							rs1_val - src : rs1_val + src;
					end
					rvs_pkg::F3_SLT: alu = {31'd0, ($signed(rs1_val) < $signed(src))};
					rvs_pkg::F3_OR:  alu = rs1_val | src;
					rvs_pkg::F3_AND: alu = rs1_val & src;
					default:         alu = rs1_val + src;
				endcase
			end
			default: begin
				alu = rs1_val + rs2_val;
			end
		endcase

		addr_ok = ({2'b00, alu[31:2]} < 32'(DATA_WORDS));

		ex.alu = alu;
		ex.rd = rd;
		ex.is_load = is_load;
		ex.reg_we = (rd != 5'd0) && (alu_wr || (is_load && addr_ok));
		ex.mem_we = is_store && addr_ok;
		ex.word_addr = alu[31:2];
		ex.mem_addr = (is_load || is_store) ? alu[13:2] : 12'd0;
		ex.store_value = (is_store && addr_ok) ? rs2_val : 32'd0;
		ex.taken = taken;
		ex.next_pc = taken ? pc_branch : pc_plus4;
	end

endmodule

>>> rtl/rv32i_subset_single_cycle_core.sv
// Small RV32I core for lw, sw, beq, add, sub, and, or, slt, addi, andi, ori and slti, driven
// one command beat at a time. An execute beat runs in order through the instruction memory
// read at the program counter, the register file read, the ALU with the data memory read, and
// write-back, which also delivers the result beat and waits while the output register is held;
// load and register-write beats finish as they are taken. The engine works on one command at a
// time because each instruction depends on the program counter and registers left by the one
// before, while an input register accepts the next beat and an output register holds a finished
// result until it is taken. After reset the data memory is cleared word by word, during which
// command beats are stalled; configuration writes are accepted at any time.
module rv32i_subset_single_cycle_core #(
	parameter int DATA_WORDS = rvs_pkg::DATA_WORDS_DEF,
	parameter int INSTR_WORDS = rvs_pkg::INSTR_WORDS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cmd_valid,
	output logic                cmd_stall,
	input  rvs_pkg::cmd_item_t  cmd_item,
	output logic                res_valid,
	input  logic                res_stall,
	output rvs_pkg::res_item_t  res_item,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [31:0]         cfg_data
);

	localparam int DAW = (DATA_WORDS > 1) ? $clog2(DATA_WORDS) : 1;
	localparam int IAW = (INSTR_WORDS > 1) ? $clog2(INSTR_WORDS) : 1;
	localparam int RAW = $clog2(rvs_pkg::REG_COUNT);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_FETCH = 4'b0010,
		ST_READ = 4'b0100,
		ST_MEM = 4'b1000
	} state_t;

	state_t state_q;
	logic buf_valid_q;
	rvs_pkg::cmd_item_t buf_q;
	logic res_valid_q;
	rvs_pkg::res_item_t res_q;
	logic clr_q;
	logic [DAW-1:0] clr_cnt_q;
	logic [31:0] pc_q;
	logic [rvs_pkg::REG_COUNT-1:0] rf_valid_q;
	logic fetch_ok_q;
	logic [31:0] instr_q;
	rvs_pkg::ex_t ex_q;

	logic out_free;
	logic take;
	logic finish;
	logic cmd_accept;
	logic [31:0] midx_ext;
	logic midx_instr_ok;
	logic midx_data_ok;

	logic i_we;
	logic [IAW-1:0] i_waddr;
	logic i_re;
	logic [IAW-1:0] i_raddr;
	logic [31:0] i_rdata;
	logic [31:0] fetched;

	logic rf_we;
	logic [RAW-1:0] rf_waddr;
	logic [31:0] rf_wdata;
	logic rf_re;
	logic [31:0] rf1_rdata;
	logic [31:0] rf2_rdata;
	logic [31:0] rs1_val;
	logic [31:0] rs2_val;

	logic d_we;
	logic [DAW-1:0] d_waddr;
	logic [31:0] d_wdata;
	logic d_re;
	logic [31:0] d_rdata;

	rvs_pkg::ex_t ex_c;
	rvs_pkg::res_item_t res_fin;

	assign out_free = !res_valid_q || !res_stall;
	assign take = (state_q == ST_IDLE) && buf_valid_q && !clr_q &&
		((buf_q.cmd == rvs_pkg::CMD_EXEC) || out_free);
	assign finish = (state_q == ST_MEM) && out_free;
	assign cmd_stall = clr_q || (buf_valid_q && !take);
	assign cmd_accept = cmd_valid && !cmd_stall;
	assign cfg_ready = 1'b1;
	assign res_valid = res_valid_q;
	assign res_item = res_q;

	assign midx_ext = {20'd0, buf_q.mem_index};
	assign midx_instr_ok = (midx_ext < 32'(INSTR_WORDS));
	assign midx_data_ok = (midx_ext < 32'(DATA_WORDS));

	assign i_we = take && (buf_q.cmd == rvs_pkg::CMD_LOAD_INSTR) && midx_instr_ok;
	assign i_waddr = midx_ext[IAW-1:0];
	assign i_re = take && (buf_q.cmd == rvs_pkg::CMD_EXEC);
	assign i_raddr = pc_q[IAW+1:2];
	assign fetched = fetch_ok_q ? i_rdata : 32'd0;

	rvs_ram #(.WIDTH(32), .DEPTH(INSTR_WORDS)) u_instr_ram (
		.clk(clk), .we(i_we), .waddr(i_waddr), .wdata(buf_q.load_value),
		.re(i_re), .raddr(i_raddr), .rdata(i_rdata)
	);

	always_comb begin
		rf_we = 1'b0;
		rf_waddr = buf_q.reg_index;
		rf_wdata = buf_q.load_value;
		if (finish) begin
			rf_we = ex_q.reg_we;
			rf_waddr = ex_q.rd;
			rf_wdata = ex_q.is_load ? d_rdata : ex_q.alu;
		end else if (take && buf_q.cmd == rvs_pkg::CMD_WRITE_REG) begin
			rf_we = (buf_q.reg_index != 5'd0);
		end
	end

	assign rf_re = (state_q == ST_FETCH);

	rvs_ram #(.WIDTH(32), .DEPTH(rvs_pkg::REG_COUNT)) u_rf_a (
		.clk(clk), .we(rf_we), .waddr(rf_waddr), .wdata(rf_wdata),
		.re(rf_re), .raddr(fetched[19:15]), .rdata(rf1_rdata)
	);

	rvs_ram #(.WIDTH(32), .DEPTH(rvs_pkg::REG_COUNT)) u_rf_b (
		.clk(clk), .we(rf_we), .waddr(rf_waddr), .wdata(rf_wdata),
		.re(rf_re), .raddr(fetched[24:20]), .rdata(rf2_rdata)
	);

	assign rs1_val = rf_valid_q[instr_q[19:15]] ? rf1_rdata : 32'd0;
	assign rs2_val = rf_valid_q[instr_q[24:20]] ? rf2_rdata : 32'd0;

	rvs_exec #(.DATA_WORDS(DATA_WORDS)) u_exec (
		.instr(instr_q), .pc(pc_q), .rs1_val(rs1_val), .rs2_val(rs2_val), .ex(ex_c)
	);

	always_comb begin
		d_we = 1'b0;
		d_waddr = midx_ext[DAW-1:0];
		d_wdata = buf_q.load_value;
		priority if (clr_q) begin
			d_we = 1'b1;
			d_waddr = clr_cnt_q;
			d_wdata = 32'd0;
		end else if (finish) begin
			d_we = ex_q.mem_we;
			d_waddr = ex_q.word_addr[DAW-1:0];
			d_wdata = ex_q.store_value;
		end else if (take && buf_q.cmd == rvs_pkg::CMD_LOAD_DATA) begin
			d_we = midx_data_ok;
		end else begin
			d_we = 1'b0;
		end
	end

	assign d_re = (state_q == ST_READ) && ex_c.is_load && ex_c.reg_we;

	rvs_ram #(.WIDTH(32), .DEPTH(DATA_WORDS)) u_data_ram (
		.clk(clk), .we(d_we), .waddr(d_waddr), .wdata(d_wdata),
		.re(d_re), .raddr(ex_c.word_addr[DAW-1:0]), .rdata(d_rdata)
	);

	always_comb begin
		res_fin.pc = pc_q;
		res_fin.instruction = instr_q;
		res_fin.alu_value = ex_q.alu;
		res_fin.reg_written = ex_q.reg_we;
		res_fin.dest_reg = ex_q.rd;
		res_fin.write_value = ex_q.reg_we ? rf_wdata : 32'd0;
		res_fin.mem_written = ex_q.mem_we;
		res_fin.mem_word_address = ex_q.mem_addr;
		res_fin.store_value = ex_q.store_value;
		res_fin.branch_taken = ex_q.taken;
		res_fin.next_pc = ex_q.next_pc;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			buf_valid_q <= 1'b0;
			res_valid_q <= 1'b0;
			clr_q <= 1'b1;
			clr_cnt_q <= '0;
			pc_q <= rvs_pkg::START_PC_RESET;
			rf_valid_q <= '0;
		end else begin
			if (cmd_accept) begin
				buf_valid_q <= 1'b1;
			end else if (take) begin
				buf_valid_q <= 1'b0;
			end

			if (clr_q) begin
				clr_cnt_q <= clr_cnt_q + 1'b1;
				if (clr_cnt_q == DAW'(DATA_WORDS - 1)) begin
					clr_q <= 1'b0;
				end
			end

			if ((take && buf_q.cmd != rvs_pkg::CMD_EXEC) || finish) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end

			if (rf_we) begin
				rf_valid_q[rf_waddr] <= 1'b1;
			end

			if (cfg_valid && cfg_ready) begin
				pc_q <= cfg_data;
			end else if (finish) begin
				pc_q <= ex_q.next_pc;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (take && buf_q.cmd == rvs_pkg::CMD_EXEC) begin
						state_q <= ST_FETCH;
					end
				end
				ST_FETCH: state_q <= ST_READ;
				ST_READ:  state_q <= ST_MEM;
				ST_MEM: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_accept) begin
			buf_q <= cmd_item;
		end
		if (i_re) begin
			fetch_ok_q <= ({2'b00, pc_q[31:2]} < 32'(INSTR_WORDS));
		end
		if (state_q == ST_FETCH) begin
			instr_q <= fetched;
		end
		if (state_q == ST_READ) begin
			ex_q <= ex_c;
		end
		if (finish) begin
			res_q <= res_fin;
		end else if (take && buf_q.cmd != rvs_pkg::CMD_EXEC) begin
			res_q <= '0;
		end
	end

`ifndef SYNTHESIS
	a_no_take_while_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		clr_q |-> !take)
		else $error("Command taken during the data memory clearing pass.");

	a_exec_sequence: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_FETCH |=> state_q == ST_READ ##1 state_q == ST_MEM)
		else $error("Execute sequence left its order.");

	a_data_port_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		!(d_we && d_re))
		else $error("Data memory written and read in the same cycle.");

	a_no_x0_write: assert property (@(posedge clk) disable iff (!arst_n)
		rf_we |-> rf_waddr != '0)
		else $error("Register x0 written.");
`endif

endmodule

>>> test/tb_rv32i_subset_single_cycle_core.sv
`timescale 1ns / 1ps

module tb_rv32i_subset_single_cycle_core;
	import rvs_pkg::*;

	localparam int DMEM_WORDS = DATA_WORDS_DEF;
	localparam int IMEM_WORDS = INSTR_WORDS_DEF;
	localparam int DMEM_AW = $clog2(DMEM_WORDS);
	localparam int IMEM_AW = $clog2(IMEM_WORDS);
	localparam int TARGET_ITEMS = 1650;
	localparam int PHASE_ITEMS = 120;
	localparam int LONG_HOLD = 300;
	localparam int SETTLE_CYCLES = 12;
	localparam int CYCLE_LIMIT = 400000;
	localparam int PRINT_LIMIT = 100;

	localparam logic [2:0] F3_WORD = 3'd2;
	localparam logic [2:0] F3_BEQ = 3'd0;
	localparam logic [2:0] F3_OTHER = 3'd1;
	localparam logic [6:0] F7_BASE = 7'h00;
	localparam logic [6:0] F7_OTHER = 7'h01;
	localparam logic [6:0] OP_UNKNOWN = 7'h37;

	logic clk;
	logic arst_n;
	logic cmd_valid;
	logic cmd_stall;
	cmd_item_t cmd_item;
	logic res_valid;
	logic res_stall;
	res_item_t res_item;
	logic cfg_valid;
	logic cfg_ready;
	logic [31:0] cfg_data;

	logic [31:0] model_pc;
	logic [31:0] model_regs [REG_COUNT];
	logic [31:0] model_dmem [DMEM_WORDS];
	logic [31:0] model_imem [IMEM_WORDS];
	bit imem_loaded [IMEM_WORDS];
	res_item_t expected_results [$];

	int mismatch_count = 0;
	int beats_checked = 0;
	int items_sent = 0;
	int cycle_count = 0;
	int cmd_max_gap = 5;
	int res_max_gap = 5;
	bit hold_request = 1'b0;

	rv32i_subset_single_cycle_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_valid(cmd_valid),
		.cmd_stall(cmd_stall),
		.cmd_item(cmd_item),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res_item(res_item),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin : watchdog
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("rv32i_subset_single_cycle_core: mismatch");
		$finish;
	end

	function automatic logic [31:0] enc_r(logic [6:0] f7, logic [4:0] rs2, logic [4:0] rs1,
			logic [2:0] f3, logic [4:0] rd, logic [6:0] op);
		return {f7, rs2, rs1, f3, rd, op};
	endfunction

	function automatic logic [31:0] enc_i(logic [11:0] imm, logic [4:0] rs1, logic [2:0] f3,
			logic [4:0] rd, logic [6:0] op);
		return {imm, rs1, f3, rd, op};
	endfunction

	function automatic logic [31:0] enc_s(logic [11:0] imm, logic [4:0] rs2, logic [4:0] rs1,
			logic [2:0] f3);
		return {imm[11:5], rs2, rs1, f3, imm[4:0], OP_STORE};
	endfunction

	function automatic logic [31:0] enc_b(logic [12:0] off, logic [4:0] rs2, logic [4:0] rs1,
			logic [2:0] f3);
		return {off[12], off[10:5], rs2, rs1, f3, off[4:1], off[11], OP_BRANCH};
	endfunction

	function automatic res_item_t core_step(cmd_item_t it);
		res_item_t r;
		logic [31:0] w, a, b, src, alu, nxt, word_addr, wv, sv;
		logic [31:0] imm_iv, imm_sv, imm_bv;
		logic [11:0] s12;
		logic [12:0] b13;
		logic [6:0] op;
		logic [4:0] rd;
		logic rw, mw, taken;
		r = '0;
		if (it.cmd == CMD_LOAD_INSTR) begin
			if (it.mem_index < IMEM_WORDS) begin
				model_imem[it.mem_index[IMEM_AW-1:0]] = it.load_value;
				imem_loaded[it.mem_index[IMEM_AW-1:0]] = 1'b1;
			end
			return r;
		end
		if (it.cmd == CMD_LOAD_DATA) begin
			if (it.mem_index < DMEM_WORDS)
				model_dmem[it.mem_index[DMEM_AW-1:0]] = it.load_value;
			return r;
		end
		if (it.cmd == CMD_WRITE_REG) begin
			if (it.reg_index != 5'd0)
				model_regs[it.reg_index] = it.load_value;
			return r;
		end

		w = (model_pc[31:2] < IMEM_WORDS) ? model_imem[model_pc[IMEM_AW+1:2]] : '0;
		op = w[6:0];
		rd = w[11:7];
		a = model_regs[w[19:15]];
		b = model_regs[w[24:20]];
		imm_iv = 32'($signed(w[31:20]));
		s12 = {w[31:25], w[11:7]};
		imm_sv = 32'($signed(s12));
		b13 = {w[31], w[7], w[30:25], w[11:8], 1'b0};
		imm_bv = 32'($signed(b13));
		nxt = model_pc + 32'd4;
		alu = a + b;
		word_addr = '0;
		wv = '0;
		sv = '0;
		rw = 1'b0;
		mw = 1'b0;
		taken = 1'b0;
		case (op)
			OP_LOAD: begin
				alu = a + imm_iv;
				word_addr = alu >> 2;
				if (word_addr < DMEM_WORDS && rd != 5'd0) begin
					wv = model_dmem[word_addr[DMEM_AW-1:0]];
					rw = 1'b1;
				end
			end
			OP_STORE: begin
				alu = a + imm_sv;
				word_addr = alu >> 2;
				if (word_addr < DMEM_WORDS) begin
					model_dmem[word_addr[DMEM_AW-1:0]] = b;
					mw = 1'b1;
					sv = b;
				end
			end
			OP_BRANCH: begin
				alu = a - b;
				if (alu == '0) begin
					taken = 1'b1;
					nxt = model_pc + imm_bv;
				end
			end
			OP_REG, OP_IMM: begin
				src = (op == OP_IMM) ? imm_iv : b;
				case (w[14:12])
					F3_ADD: alu = (op == OP_REG && w[31:25] == F7_SUB) ? a - src : a + src;
					F3_SLT: alu = ($signed(a) < $signed(src)) ? 32'd1 : 32'd0;
					F3_OR: alu = a | src;
					F3_AND: alu = a & src;
					default: alu = a + src;
				endcase
				if (rd != 5'd0) begin
					wv = alu;
					rw = 1'b1;
				end
			end
			default: ;
		endcase

		r.pc = model_pc;
		r.instruction = w;
		r.alu_value = alu;
		r.reg_written = rw;
		r.dest_reg = rd;
		r.write_value = wv;
		r.mem_written = mw;
		r.mem_word_address = word_addr[11:0];
		r.store_value = sv;
		r.branch_taken = taken;
		r.next_pc = nxt;
		if (rw)
			model_regs[rd] = wv;
		model_pc = nxt;
		return r;
	endfunction

	function automatic logic [31:0] random_instr();
		logic [4:0] rs1, rs2, rd;
		logic [11:0] imm;
		logic [12:0] off;
		logic [2:0] f3;
		rs1 = 5'($urandom_range(0, 31));
		rs2 = 5'($urandom_range(0, 31));
		rd = 5'($urandom_range(0, 31));
		imm = 12'($urandom());
		f3 = 3'($urandom_range(0, 7));
		case ($urandom_range(0, 12))
			0: begin
				if ($urandom_range(0, 1)) begin
					rs1 = 5'd0;
					imm = 12'($urandom_range(0, 2047));
				end
				return enc_i(imm, rs1, F3_WORD, rd, OP_LOAD);
			end
			1: begin
				if ($urandom_range(0, 1)) begin
					rs1 = 5'd0;
					imm = 12'($urandom_range(0, 2047));
				end
				return enc_s(imm, rs2, rs1, F3_WORD);
			end
			2: begin
				if ($urandom_range(0, 2) == 0)
					rs2 = rs1;
				if ($urandom_range(0, 1))
					off = 13'($urandom_range(0, 16) * 4 - 32);
				else
					off = 13'($urandom()) & 13'h1FFE;
				return enc_b(off, rs2, rs1, ($urandom_range(0, 3) == 0) ? f3 : F3_BEQ);
			end
			3: return enc_r(F7_BASE, rs2, rs1, F3_ADD, rd, OP_REG);
			4: return enc_r(F7_SUB, rs2, rs1, F3_ADD, rd, OP_REG);
			5: return enc_r(F7_BASE, rs2, rs1, F3_AND, rd, OP_REG);
			6: return enc_r(F7_BASE, rs2, rs1, F3_OR, rd, OP_REG);
			7: return enc_r(F7_BASE, rs2, rs1, F3_SLT, rd, OP_REG);
			8: return enc_i(imm, rs1, F3_ADD, rd, OP_IMM);
			9: return enc_i(imm, rs1, f3, rd, OP_IMM);
			10: return enc_r(7'($urandom()), rs2, rs1, f3, rd, OP_REG);
			11: return enc_i(imm, rs1, f3, rd, OP_UNKNOWN);
			default: return $urandom();
		endcase
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got_v, logic [31:0] want_v);
		mismatch_count++;
		if (mismatch_count <= PRINT_LIMIT)
			$display("%0t ns beat %0d %s: got %h, want %h", $time, beats_checked, what,
				got_v, want_v);
	endtask

	task automatic check_result(res_item_t got);
		res_item_t want;
		beats_checked++;
		if (expected_results.size() == 0) begin
			report_mismatch("beat with nothing expected", got.pc, '0);
			return;
		end
		want = expected_results.pop_front();
		if (got.pc !== want.pc)
			report_mismatch("pc", got.pc, want.pc);
		if (got.instruction !== want.instruction)
			report_mismatch("instruction", got.instruction, want.instruction);
		if (got.alu_value !== want.alu_value)
			report_mismatch("alu_value", got.alu_value, want.alu_value);
		if (got.reg_written !== want.reg_written)
			report_mismatch("reg_written", 32'(got.reg_written), 32'(want.reg_written));
		if (got.dest_reg !== want.dest_reg)
			report_mismatch("dest_reg", 32'(got.dest_reg), 32'(want.dest_reg));
		if (got.write_value !== want.write_value)
			report_mismatch("write_value", got.write_value, want.write_value);
		if (got.mem_written !== want.mem_written)
			report_mismatch("mem_written", 32'(got.mem_written), 32'(want.mem_written));
		if (got.mem_word_address !== want.mem_word_address)
			report_mismatch("mem_word_address", 32'(got.mem_word_address),
				32'(want.mem_word_address));
		if (got.store_value !== want.store_value)
			report_mismatch("store_value", got.store_value, want.store_value);
		if (got.branch_taken !== want.branch_taken)
			report_mismatch("branch_taken", 32'(got.branch_taken), 32'(want.branch_taken));
		if (got.next_pc !== want.next_pc)
			report_mismatch("next_pc", got.next_pc, want.next_pc);
	endtask

	initial begin : result_side
		int gap;
		int hold_left;
		gap = 0;
		hold_left = 0;
		res_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && res_valid && !res_stall) begin
				check_result(res_item);
				gap = $urandom_range(0, res_max_gap);
			end
			if (hold_left > 0) begin
				hold_left--;
				res_stall <= 1'b1;
			end else if (hold_request) begin
				hold_request = 1'b0;
				hold_left = LONG_HOLD;
				res_stall <= 1'b1;
			end else if (gap > 0) begin
				gap--;
				res_stall <= 1'b1;
			end else begin
				res_stall <= 1'b0;
			end
		end
	end

	// Valid is left high after a beat so that a following beat with no gap goes straight on;
	// anything that lets time pass without sending must lower it first.
	task automatic send_cmd(cmd_t c, logic [11:0] mi, logic [4:0] ri, logic [31:0] v);
		cmd_item_t it;
		int gap;
		it.cmd = c;
		it.mem_index = mi;
		it.reg_index = ri;
		it.load_value = v;
		gap = $urandom_range(0, cmd_max_gap);
		if (gap > 0) begin
			cmd_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_valid <= 1'b1;
		cmd_item <= it;
		do @(posedge clk); while (cmd_stall);
		expected_results.push_back(core_step(it));
		items_sent++;
	endtask

	task automatic drain_results();
		cmd_valid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_start_pc(logic [31:0] v);
		drain_results();
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		model_pc = v;
	endtask

	task automatic run_instr(logic [31:0] w);
		if (model_pc[31:2] < IMEM_WORDS)
			send_cmd(CMD_LOAD_INSTR, model_pc[13:2], 5'($urandom()), w);
		send_cmd(CMD_EXEC, 12'($urandom()), 5'($urandom()), $urandom());
	endtask

	// Never executes an unloaded word inside the instruction memory; beyond it, a zero word is fetched.
	task automatic random_exec();
		if (model_pc[31:2] >= IMEM_WORDS && $urandom_range(0, 3) != 0)
			write_start_pc($urandom_range(0, IMEM_WORDS - 1) << 2);
		if (model_pc[31:2] < IMEM_WORDS &&
				(!imem_loaded[model_pc[IMEM_AW+1:2]] || $urandom_range(0, 1)))
			run_instr(random_instr());
		else
			send_cmd(CMD_EXEC, 12'($urandom()), 5'($urandom()), $urandom());
	endtask

	task automatic random_beat();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 12)
			send_cmd(CMD_WRITE_REG, 12'($urandom()), 5'($urandom()),
				$urandom_range(0, 1) ? $urandom_range(0, 16383) : $urandom());
		else if (pick < 20)
			send_cmd(CMD_LOAD_DATA, 12'($urandom()), 5'($urandom()), $urandom());
		else if (pick < 25)
			send_cmd(CMD_LOAD_INSTR, 12'($urandom()), 5'($urandom()), random_instr());
		else
			random_exec();
	endtask

	task automatic test_directed_ops();
		cmd_max_gap = 5;
		res_max_gap = 5;
		send_cmd(CMD_WRITE_REG, 12'd0, 5'd0, 32'hFFFF_FFFF);
		send_cmd(CMD_WRITE_REG, 12'hFFF, 5'd1, 32'hFFFF_FFFF);
		send_cmd(CMD_WRITE_REG, 12'd0, 5'd2, 32'h7FFF_FFFF);
		send_cmd(CMD_WRITE_REG, 12'd0, 5'd3, 32'h8000_0000);
		send_cmd(CMD_WRITE_REG, 12'd0, 5'd31, 32'h0000_0040);
		send_cmd(CMD_LOAD_DATA, 12'd16, 5'd0, 32'hA5A5_5A5A);
		send_cmd(CMD_LOAD_DATA, 12'hFFF, 5'd31, 32'h0000_0000);
		send_cmd(CMD_LOAD_INSTR, 12'hFFF, 5'd0, 32'hFFFF_FFFF);
		run_instr(enc_r(F7_BASE, 5'd2, 5'd1, F3_ADD, 5'd5, OP_REG));
		run_instr(enc_r(F7_SUB, 5'd3, 5'd1, F3_ADD, 5'd6, OP_REG));
		run_instr(enc_r(F7_BASE, 5'd3, 5'd1, F3_AND, 5'd7, OP_REG));
		run_instr(enc_r(F7_BASE, 5'd3, 5'd2, F3_OR, 5'd8, OP_REG));
		run_instr(enc_r(F7_BASE, 5'd2, 5'd3, F3_SLT, 5'd9, OP_REG));
		run_instr(enc_r(F7_BASE, 5'd3, 5'd2, F3_SLT, 5'd10, OP_REG));
		run_instr(enc_r(F7_SUB, 5'd2, 5'd1, F3_OTHER, 5'd11, OP_REG));
		run_instr(enc_r(F7_OTHER, 5'd2, 5'd1, F3_ADD, 5'd12, OP_REG));
		run_instr(enc_i(12'hFFF, 5'd0, F3_ADD, 5'd13, OP_IMM));
		run_instr(enc_i({F7_SUB, 5'd1}, 5'd1, F3_ADD, 5'd14, OP_IMM));
		run_instr(enc_i(12'h7FF, 5'd2, F3_ADD, 5'd0, OP_IMM));
		run_instr(enc_i(12'd0, 5'd31, F3_WORD, 5'd15, OP_LOAD));
		run_instr(enc_i(12'd4, 5'd0, F3_WORD, 5'd0, OP_LOAD));
		run_instr(enc_i(12'hFFC, 5'd0, F3_WORD, 5'd16, OP_LOAD));
		run_instr(enc_s(12'd4, 5'd1, 5'd31, F3_WORD));
		run_instr(enc_s(12'd0, 5'd2, 5'd3, F3_WORD));
		run_instr(enc_i(12'd4, 5'd31, F3_WORD, 5'd17, OP_LOAD));
		run_instr(enc_b(13'd8, 5'd1, 5'd1, F3_BEQ));
		run_instr(enc_b(13'd8, 5'd2, 5'd1, F3_BEQ));
		run_instr(enc_b(13'h1FF0, 5'd0, 5'd0, F3_AND));
		run_instr(enc_r(F7_BASE, 5'd1, 5'd2, F3_ADD, 5'd18, OP_UNKNOWN));
	endtask

	task automatic test_start_pc_extremes();
		cmd_max_gap = 0;
		res_max_gap = 0;
		write_start_pc(32'hFFFF_FFFC);
		send_cmd(CMD_EXEC, '0, '0, '0);
		run_instr(enc_i(12'd1, 5'd1, F3_ADD, 5'd1, OP_IMM));
		write_start_pc(32'h0000_0000);
		run_instr(enc_b(13'h1FFC, 5'd0, 5'd0, F3_BEQ));
		send_cmd(CMD_EXEC, '0, '0, '0);
		write_start_pc((IMEM_WORDS - 1) << 2);
		run_instr(enc_i(12'hFFF, 5'd2, F3_SLT, 5'd3, OP_IMM));
		send_cmd(CMD_EXEC, '0, '0, '0);
		write_start_pc(32'hAAAA_AAA8);
		send_cmd(CMD_EXEC, 12'hFFF, 5'd31, 32'hFFFF_FFFF);
		write_start_pc(32'h5555_5554);
		send_cmd(CMD_EXEC, 12'hFFF, 5'd31, 32'hFFFF_FFFF);
		write_start_pc(START_PC_RESET);
	endtask

	// The result side holds off for a long stretch while command beats keep coming, so the
	// core fills up and has to stall its input.
	task automatic test_input_backpressure();
		cmd_max_gap = 0;
		res_max_gap = 5;
		hold_request = 1'b1;
		repeat (60) random_beat();
		drain_results();
	endtask

	task automatic test_random_programs();
		int phase_left;
		phase_left = 0;
		while (items_sent < TARGET_ITEMS) begin
			if (phase_left == 0) begin
				if ($urandom_range(0, 3) == 0)
					write_start_pc($urandom() & 32'hFFFF_FFFC);
				else
					write_start_pc($urandom_range(0, IMEM_WORDS - 1) << 2);
				cmd_max_gap = ($urandom_range(0, 2) == 0) ? 0 : 5;
				res_max_gap = ($urandom_range(0, 2) == 0) ? 0 : 5;
				phase_left = PHASE_ITEMS;
			end
			random_beat();
			phase_left--;
		end
	endtask

	initial begin
		arst_n <= 1'b0;
		cmd_valid <= 1'b0;
		cmd_item <= '0;
		cfg_valid <= 1'b0;
		cfg_data <= '0;
		model_pc = START_PC_RESET;
		foreach (model_regs[i])
			model_regs[i] = '0;
		foreach (model_dmem[i])
			model_dmem[i] = '0;
		foreach (imem_loaded[i])
			imem_loaded[i] = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		test_directed_ops();
		test_start_pc_extremes();
		test_input_backpressure();
		test_random_programs();
		drain_results();

		if (mismatch_count == 0)
			$display("rv32i_subset_single_cycle_core: match");
		else
			$display("rv32i_subset_single_cycle_core: mismatch");
		$finish;
	end

endmodule
